[hdl/wss_pkg.sv]
package wss_pkg;

    localparam int IN_W                  = 32;
    localparam int SAMPLE_W              = 16;
    localparam int STORED_W              = 5;
    localparam int QUO_W                 = 16;
    localparam int STEP_W                = $clog2(QUO_W);
    localparam int HISTORY_DEPTH_DEFAULT = 16;

    localparam logic [SAMPLE_W-1:0] MAX_VALID_RESET = 16'd4999;

endpackage

[hdl/wss_ifs.sv]
interface wss_sample_if import wss_pkg::*;;
    logic                valid;
    logic                ready;
    logic [IN_W-1:0]     sample_value;

    modport source (output valid, output sample_value, input ready);
    modport sink   (input valid, input sample_value, output ready);
endinterface

interface wss_result_if import wss_pkg::*;;
    logic                valid;
    logic                ready;
    logic                accepted;
    logic [SAMPLE_W-1:0] current_sample;
    logic [SAMPLE_W-1:0] average_sample;
    logic [SAMPLE_W-1:0] minimum_sample;
    logic [SAMPLE_W-1:0] maximum_sample;
    logic [STORED_W-1:0] stored_count;

    modport source (output valid, output accepted, output current_sample,
                    output average_sample, output minimum_sample,
                    output maximum_sample, output stored_count, input ready);
    modport sink   (input valid, input accepted, input current_sample,
                    input average_sample, input minimum_sample,
                    input maximum_sample, input stored_count, output ready);
endinterface

[hdl/wss_ring.sv]
module wss_ring import wss_pkg::*;
#(
    parameter int DEPTH  = HISTORY_DEPTH_DEFAULT,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic                clk,
    input  logic                wr_en,
    input  logic [ADDR_W-1:0]   wr_addr,
    input  logic [SAMPLE_W-1:0] wr_data,
    input  logic                rd_en,
    input  logic [ADDR_W-1:0]   rd_addr,
    output logic [SAMPLE_W-1:0] rd_data
);

    logic [SAMPLE_W-1:0] mem [DEPTH];
    logic [SAMPLE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hdl/wss_div.sv]
module wss_div import wss_pkg::*;
#(
    parameter int CNT_W = 5,
    parameter int SUM_W = SAMPLE_W + CNT_W
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [SUM_W-1:0] dividend,
    input  logic [CNT_W-1:0] divisor,
    output logic             done,
    output logic [QUO_W-1:0] quotient
);

    localparam int DIV_W = CNT_W + QUO_W;

    logic              busy_reg,  busy_next;
    logic              done_reg,  done_next;
    logic [STEP_W-1:0] step_reg,  step_next;
    logic [DIV_W-1:0]  rem_reg,   rem_next;
    logic [DIV_W-1:0]  dsh_reg,   dsh_next;
    logic [QUO_W-1:0]  q_reg,     q_next;
    logic              ge;

    assign ge = (rem_reg >= dsh_reg);

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        q_next    = q_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = STEP_W'(QUO_W - 1);
            rem_next  = DIV_W'(dividend);
            dsh_next  = DIV_W'(divisor) << (QUO_W - 1);
            q_next    = '0;
        end
        else if (busy_reg)
        begin
            // one restoring step per cycle
            rem_next  = ge ? (rem_reg - dsh_reg) : rem_reg;
            q_next    = {q_reg[QUO_W-2:0], ge};
            dsh_next  = dsh_reg >> 1;
            step_next = step_reg - 1'b1;
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        q_reg   <= q_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

[hdl/windowed_sample_statistics.sv]
// Windowed sample statistics.
// sample_chan (sink) takes one sample request per item; result_chan
// (source) returns one result request per item: accepted flag, newest
// stored sample, truncated mean, minimum, maximum and fill count.
// A sample of zero or above max_valid_sample is rejected and not stored.
// max_valid_sample is written via max_valid_sample_we; the user must
// do so only while idle, as the block does not enforce it. One item
// at a time: sample_chan.ready is high only when idle. After accept the
// block reads the ring once per cycle over F entries, F being the fill
// count after the item (registered read), then runs the serial divider,
// which produces one quotient bit per cycle. With an empty ring no entry
// is read and the divide is skipped.
// The result is held in the output registers until result_chan.ready;
// no new sample is taken meanwhile.
// Reset clears the write pointer, fill count and sequencer and loads
// max_valid_sample with 4999; ring contents are not cleared.
module windowed_sample_statistics import wss_pkg::*;
#(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEFAULT
)
(
    input  logic                clk,
    input  logic                rst_n,
    wss_sample_if.sink          sample_chan,
    wss_result_if.source        result_chan,
    input  logic                max_valid_sample_we,
    input  logic [SAMPLE_W-1:0] max_valid_sample
);

    localparam int ADDR_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
    localparam int SUM_W  = SAMPLE_W + CNT_W;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_WALK = 4'b0010,
        S_DIV  = 4'b0100,
        S_OUT  = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    logic [SAMPLE_W-1:0] limit_reg;
    logic [ADDR_W-1:0]   wp_reg,    wp_next;
    logic [CNT_W-1:0]    fill_reg,  fill_next;
    logic [CNT_W-1:0]    idx_reg,   idx_next;
    logic                pend_reg,  pend_next;
    logic                acc_reg,   acc_next;
    logic [SAMPLE_W-1:0] last_reg,  last_next;
    logic [SUM_W-1:0]    sum_reg,   sum_next;
    logic [SAMPLE_W-1:0] min_reg,   min_next;
    logic [SAMPLE_W-1:0] max_reg,   max_next;
    logic [SAMPLE_W-1:0] avg_reg,   avg_next;

    logic                in_fire;
    logic                sample_ok;
    logic                ring_we;
    logic                rd_en;
    logic [SAMPLE_W-1:0] rd_data;
    logic                div_start;
    logic                div_done;
    logic [QUO_W-1:0]    div_q;
    logic                empty;

    assign in_fire   = sample_chan.valid && sample_chan.ready;
    assign sample_ok = (sample_chan.sample_value != '0) &&
                       (sample_chan.sample_value <= IN_W'(limit_reg));

    wss_ring #(
        .DEPTH  (HISTORY_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ring (
        .clk     (clk),
        .wr_en   (ring_we),
        .wr_addr (wp_reg),
        .wr_data (sample_chan.sample_value[SAMPLE_W-1:0]),
        .rd_en   (rd_en),
        .rd_addr (idx_reg[ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    wss_div #(
        .CNT_W (CNT_W),
        .SUM_W (SUM_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (fill_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        state_next = state_reg;
        wp_next    = wp_reg;
        fill_next  = fill_reg;
        idx_next   = idx_reg;
        pend_next  = pend_reg;
        acc_next   = acc_reg;
        last_next  = last_reg;
        sum_next   = sum_reg;
        min_next   = min_reg;
        max_next   = max_reg;
        avg_next   = avg_reg;
        ring_we    = 1'b0;
        rd_en      = 1'b0;
        div_start  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    acc_next = sample_ok;
                    if (sample_ok)
                    begin
                        ring_we   = 1'b1;
                        last_next = sample_chan.sample_value[SAMPLE_W-1:0];
                        wp_next   = (wp_reg == ADDR_W'(HISTORY_DEPTH - 1)) ?
                                    '0 : wp_reg + 1'b1;
                        if (fill_reg != CNT_W'(HISTORY_DEPTH))
                        begin
                            fill_next = fill_reg + 1'b1;
                        end
                    end
                    idx_next   = '0;
                    pend_next  = 1'b0;
                    sum_next   = '0;
                    min_next   = '1;
                    max_next   = '0;
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                pend_next = 1'b0;
                if (idx_reg != fill_reg)
                begin
                    rd_en     = 1'b1;
                    idx_next  = idx_reg + 1'b1;
                    pend_next = 1'b1;
                end
                if (pend_reg)
                begin
                    sum_next = sum_reg + SUM_W'(rd_data);
                    if (rd_data < min_reg)
                    begin
                        min_next = rd_data;
                    end
                    if (rd_data > max_reg)
                    begin
                        max_next = rd_data;
                    end
                end
                if ((idx_reg == fill_reg) && !pend_reg)
                begin
                    if (fill_reg == '0)
                    begin
                        state_next = S_OUT;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    avg_next   = div_q;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (result_chan.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            limit_reg <= MAX_VALID_RESET;
            wp_reg    <= '0;
            fill_reg  <= '0;
            idx_reg   <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (max_valid_sample_we)
            begin
                limit_reg <= max_valid_sample;
            end
            wp_reg    <= wp_next;
            fill_reg  <= fill_next;
            idx_reg   <= idx_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        last_reg <= last_next;
        sum_reg  <= sum_next;
        min_reg  <= min_next;
        max_reg  <= max_next;
        avg_reg  <= avg_next;
    end

    assign empty = (fill_reg == '0);

    assign sample_chan.ready          = (state_reg == S_IDLE);
    assign result_chan.valid          = (state_reg == S_OUT);
    assign result_chan.accepted       = acc_reg;
    assign result_chan.current_sample = empty ? '0 : last_reg;
    assign result_chan.average_sample = empty ? '0 : avg_reg;
    assign result_chan.minimum_sample = empty ? '0 : min_reg;
    assign result_chan.maximum_sample = empty ? '0 : max_reg;
    assign result_chan.stored_count   = STORED_W'(fill_reg);

endmodule

[hdl/wss_checker.sv]
module wss_checker import wss_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  logic                out_valid,
    input  logic                out_ready,
    input  logic                accepted,
    input  logic [SAMPLE_W-1:0] current_sample,
    input  logic [SAMPLE_W-1:0] average_sample,
    input  logic [SAMPLE_W-1:0] minimum_sample,
    input  logic [SAMPLE_W-1:0] maximum_sample
);

    // one item in flight: no new sample while a result is pending
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("sample ready while result pending");

    a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !out_valid)
        else $error("result valid straight after sample request");

    a_current_set: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && accepted) |-> (current_sample != '0))
        else $error("accepted sample reported as zero");

    a_avg_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((minimum_sample <= average_sample) &&
                       (average_sample <= maximum_sample)))
        else $error("average outside minimum and maximum");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(average_sample)))
        else $error("stalled result changed");

endmodule

bind windowed_sample_statistics wss_checker u_wss_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (sample_chan.valid),
    .in_ready       (sample_chan.ready),
    .out_valid      (result_chan.valid),
    .out_ready      (result_chan.ready),
    .accepted       (result_chan.accepted),
    .current_sample (result_chan.current_sample),
    .average_sample (result_chan.average_sample),
    .minimum_sample (result_chan.minimum_sample),
    .maximum_sample (result_chan.maximum_sample)
);

[tb/sv/sample_stats_checker.sv]
`timescale 1ns / 1ps

module sample_stats_checker import wss_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    wss_sample_if               sample_chan,
    wss_result_if               result_chan,
    input  logic                limit_we,
    input  logic [SAMPLE_W-1:0] limit_value,
    output int                  mismatch_count,
    output int                  results_owed
);

    localparam int DEPTH = HISTORY_DEPTH_DEFAULT;

    typedef struct packed {
        logic                accepted;
        logic [SAMPLE_W-1:0] current;
        logic [SAMPLE_W-1:0] average;
        logic [SAMPLE_W-1:0] minimum;
        logic [SAMPLE_W-1:0] maximum;
        logic [STORED_W-1:0] stored;
    } window_stats_t;

    logic [SAMPLE_W-1:0] window [DEPTH];
    logic [SAMPLE_W-1:0] sample_limit;
    int                  wr_ptr;
    int                  fill;
    int                  errors;
    window_stats_t       stats_q [$];

    function automatic window_stats_t absorb_sample(input logic [IN_W-1:0] s);
        window_stats_t r;
        int unsigned   total;
        logic [SAMPLE_W-1:0] lo;
        logic [SAMPLE_W-1:0] hi;
        r = '0;
        r.accepted = (s != '0) && (s <= {{(IN_W-SAMPLE_W){1'b0}}, sample_limit});
        if (r.accepted)
        begin
            window[wr_ptr] = s[SAMPLE_W-1:0];
            wr_ptr = (wr_ptr + 1) % DEPTH;
            if (fill < DEPTH)
                fill++;
        end
        if (fill != 0)
        begin
            r.current = window[(wr_ptr + DEPTH - 1) % DEPTH];
            total = 0;
            lo = '1;
            hi = '0;
            for (int i = 0; i < fill; i++)
            begin
                total += window[i];
                if (window[i] < lo)
                    lo = window[i];
                if (window[i] > hi)
                    hi = window[i];
            end
            r.average = SAMPLE_W'(total / fill);
            r.minimum = lo;
            r.maximum = hi;
        end
        r.stored = STORED_W'(fill);
        return r;
    endfunction

    function automatic void check_field(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
            errors++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        window_stats_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
                window[i] = '0;
            sample_limit = MAX_VALID_RESET;
            wr_ptr = 0;
            fill = 0;
            errors = 0;
            stats_q.delete();
            mismatch_count <= 0;
            results_owed <= 0;
        end
        else
        begin
            if (limit_we)
                sample_limit = limit_value;
            if (sample_chan.valid && sample_chan.ready)
                stats_q.push_back(absorb_sample(sample_chan.sample_value));
            if (result_chan.valid && result_chan.ready)
            begin
                if (stats_q.size() == 0)
                begin
                    $display("%0t: result request with none expected", $time);
                    errors++;
                end
                else
                begin
                    want = stats_q.pop_front();
                    check_field("accepted", 32'(want.accepted),
                                32'(result_chan.accepted));
                    check_field("current_sample", 32'(want.current),
                                32'(result_chan.current_sample));
                    check_field("average_sample", 32'(want.average),
                                32'(result_chan.average_sample));
                    check_field("minimum_sample", 32'(want.minimum),
                                32'(result_chan.minimum_sample));
                    check_field("maximum_sample", 32'(want.maximum),
                                32'(result_chan.maximum_sample));
                    check_field("stored_count", 32'(want.stored),
                                32'(result_chan.stored_count));
                end
            end
            results_owed <= stats_q.size();
            mismatch_count <= errors;
        end
    end

endmodule

[tb/sv/tb_windowed_sample_statistics.sv]
`timescale 1ns / 1ps

module tb_windowed_sample_statistics;
    import wss_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 142;
    localparam int HOLD_AFTER     = 300;
    localparam int HOLD_CYCLES    = 400;

    logic                clk;
    logic                rst_n;
    logic                limit_we;
    logic [SAMPLE_W-1:0] limit_value;
    int                  mismatch_count;
    int                  results_owed;
    int                  results_taken;
    int                  quiet_cycles;
    bit                  idling_on = 1'b1;

    wss_sample_if sample_chan ();
    wss_result_if result_chan ();

    windowed_sample_statistics dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .sample_chan         (sample_chan),
        .result_chan         (result_chan),
        .max_valid_sample_we (limit_we),
        .max_valid_sample    (limit_value)
    );

    sample_stats_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .sample_chan    (sample_chan),
        .result_chan    (result_chan),
        .limit_we       (limit_we),
        .limit_value    (limit_value),
        .mismatch_count (mismatch_count),
        .results_owed   (results_owed)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            results_taken <= 0;
        else if (result_chan.valid && result_chan.ready)
            results_taken <= results_taken + 1;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (sample_chan.valid && sample_chan.ready)
                   || (result_chan.valid && result_chan.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog expired", $time);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // result sink: random stalls, plus one long hold so the block backs up
    initial
    begin : result_sink
        bit long_hold_done;
        long_hold_done = 1'b0;
        result_chan.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (!long_hold_done && results_taken >= HOLD_AFTER)
            begin
                long_hold_done = 1'b1;
                result_chan.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (idling_on && $urandom_range(0, 2) == 0)
            begin
                result_chan.ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
            else
            begin
                result_chan.ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    task automatic send_sample(input logic [IN_W-1:0] value);
        if (idling_on && $urandom_range(0, 3) == 0)
        begin
            sample_chan.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        sample_chan.valid <= 1'b1;
        sample_chan.sample_value <= value;
        @(posedge clk);
        while (!sample_chan.ready)
            @(posedge clk);
    endtask

    task automatic drain_results();
        sample_chan.valid <= 1'b0;
        @(posedge clk);
        while (results_owed != 0 || !sample_chan.ready)
            @(posedge clk);
    endtask

    task automatic write_limit(input logic [SAMPLE_W-1:0] value);
        drain_results();
        limit_we <= 1'b1;
        limit_value <= value;
        @(posedge clk);
        limit_we <= 1'b0;
    endtask

    function automatic logic [IN_W-1:0] pick_sample(input logic [SAMPLE_W-1:0] lim);
        logic [IN_W-1:0] ceiling;
        ceiling = {{(IN_W-SAMPLE_W){1'b0}}, lim};
        case ($urandom_range(0, 9))
            0: return '0;
            1: return ceiling + 1;
            2: return ceiling;
            3: return $urandom();
            4: return 1;
            default: return (lim == '0) ? 1 : $urandom_range(1, ceiling);
        endcase
    endfunction

    initial
    begin : stimulus
        logic [SAMPLE_W-1:0] phase_limit [PHASES];
        rst_n <= 1'b0;
        limit_we <= 1'b0;
        limit_value <= '0;
        sample_chan.valid <= 1'b0;
        sample_chan.sample_value <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // reset limit; empty ring rejections first
        send_sample(32'd0);
        send_sample(32'd5000);
        send_sample(32'hFFFF_FFFF);
        send_sample(32'h0001_0001);
        send_sample(32'd1);
        send_sample(32'd4999);
        repeat (15) send_sample($urandom_range(2, 4998));

        write_limit(16'hFFFF);
        send_sample(32'h0000_FFFF);
        send_sample(32'h0001_0000);
        write_limit(16'd0);
        send_sample(32'd1);
        write_limit(16'd1);
        send_sample(32'd1);

        phase_limit[0] = 16'hFFFF;
        phase_limit[1] = 16'd1;
        phase_limit[2] = SAMPLE_W'($urandom_range(2, 65534));
        phase_limit[3] = MAX_VALID_RESET;
        phase_limit[4] = 16'd255;
        phase_limit[5] = SAMPLE_W'($urandom_range(2, 65534));
        phase_limit[6] = 16'hFFFF;
        phase_limit[7] = SAMPLE_W'($urandom_range(2, 65534));

        for (int p = 0; p < PHASES; p++)
        begin
            write_limit(phase_limit[p]);
            if (p == PHASES - 1)
                idling_on = 1'b0;
            repeat (PHASE_ITEMS) send_sample(pick_sample(phase_limit[p]));
        end

        drain_results();
        repeat (50) @(posedge clk);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
